### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and defaults of the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CMD_W         = 3;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE      = 2'd0,
        S_ACCESS    = 2'd1,
        S_WRITEBACK = 2'd2
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic access;
        logic load_result;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rsp_free;
    } dp_status_t;

endpackage

### rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for queue commands and queue responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface deq_req_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::CMD_W-1:0]         cmd;
    logic signed [deq_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                              valid;
    logic                              ready;
    logic signed [deq_pkg::DATA_W-1:0] read_value;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic                              is_empty;
    logic [CNT_W-1:0]                  occupancy;

    modport source (output valid, output read_value, output status, output is_empty,
                    output occupancy, input ready);
    modport sink   (input valid, input read_value, input status, input is_empty,
                    input occupancy, output ready);
endinterface

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: take a command, access the ring, hand the response over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  deq_pkg::dp_status_t    dp_status,
    output deq_pkg::ctrl_cmd_t     ctrl_cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = deq_pkg::S_ACCESS;
                end
            end
            deq_pkg::S_ACCESS:
            begin
                state_next = deq_pkg::S_WRITEBACK;
            end
            deq_pkg::S_WRITEBACK:
            begin
                // hold until the response register frees up
                if (dp_status.rsp_free)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready            = 1'b0;
        ctrl_cmd.load_item   = 1'b0;
        ctrl_cmd.access      = 1'b0;
        ctrl_cmd.load_result = 1'b0;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                req_ready          = 1'b1;
                ctrl_cmd.load_item = req_valid;
            end
            deq_pkg::S_ACCESS:
            begin
                ctrl_cmd.access = 1'b1;
            end
            deq_pkg::S_WRITEBACK:
            begin
                ctrl_cmd.load_result = dp_status.rsp_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl_cmd.load_item, ctrl_cmd.access, ctrl_cmd.load_result}))
        else $error("deq_ctrl: more than one datapath command at once");

    a_access_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_item |=> ctrl_cmd.access)
        else $error("deq_ctrl: accepted transaction not followed by ring access");

    a_writeback_follows_access: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.access |=> (state_reg == deq_pkg::S_WRITEBACK))
        else $error("deq_ctrl: ring access not followed by writeback");

endmodule

### rtl/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring buffer storage, head index and count, and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  deq_pkg::ctrl_cmd_t                ctrl_cmd,
    output deq_pkg::dp_status_t               dp_status,
    input  logic [deq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [deq_pkg::DATA_W-1:0] push_value,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic signed [deq_pkg::DATA_W-1:0] read_value,
    output logic [deq_pkg::STATUS_W-1:0]      status,
    output logic                              is_empty,
    output logic [CNT_W-1:0]                  occupancy
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

    logic [deq_pkg::CMD_W-1:0]  cmd_reg;
    logic [deq_pkg::DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           head_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [deq_pkg::DATA_W-1:0] rd_data_reg;
    logic                       rd_ok_reg;
    logic                       rd_ok_next;
    deq_pkg::status_t           res_status_reg;
    deq_pkg::status_t           res_status_next;

    logic                       rsp_valid_reg;
    logic [deq_pkg::DATA_W-1:0] rsp_value_reg;
    deq_pkg::status_t           rsp_status_reg;
    logic [CNT_W-1:0]           rsp_count_reg;

    logic                       ring_full;
    logic                       ring_empty;
    logic [IDX_W-1:0]           head_prev;
    logic [IDX_W-1:0]           head_succ;
    logic [SUM_W-1:0]           tail_sum;
    logic [SUM_W-1:0]           back_sum;
    logic [IDX_W-1:0]           tail_slot;
    logic [IDX_W-1:0]           back_slot;
    logic                       mem_we;
    logic                       mem_re;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;

    assign ring_full  = (count_reg == DEPTH_CNT);
    assign ring_empty = (count_reg == '0);
    assign head_prev  = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign head_succ  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);

    // one compare and subtract wraps head + count into the ring
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign back_sum  = tail_sum - SUM_W'(1);
    assign tail_slot = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                               : IDX_W'(tail_sum);
    assign back_slot = (back_sum >= DEPTH_SUM) ? IDX_W'(back_sum - DEPTH_SUM)
                                               : IDX_W'(back_sum);

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = deq_pkg::ST_OK;
        rd_ok_next      = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        wr_addr         = tail_slot;
        rd_addr         = head_reg;
        unique case (cmd_reg)
            deq_pkg::CMD_PUSH_FRONT:
            begin
                wr_addr = head_prev;
                if (ring_full)
                begin
                    res_status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = ctrl_cmd.access;
                    head_next  = head_prev;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::CMD_PUSH_BACK:
            begin
                if (ring_full)
                begin
                    res_status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = ctrl_cmd.access;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT:
            begin
                if (ring_empty)
                begin
                    res_status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    mem_re     = ctrl_cmd.access;
                    rd_ok_next = 1'b1;
                    if (cmd_reg == deq_pkg::CMD_POP_FRONT)
                    begin
                        head_next  = head_succ;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK:
            begin
                rd_addr = back_slot;
                if (ring_empty)
                begin
                    res_status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    mem_re     = ctrl_cmd.access;
                    rd_ok_next = 1'b1;
                    if (cmd_reg == deq_pkg::CMD_POP_BACK)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // unused codes: no operation, status ok
                res_status_next = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load_item)
        begin
            cmd_reg   <= cmd;
            value_reg <= push_value;
        end
        if (ctrl_cmd.access)
        begin
            res_status_reg <= res_status_next;
        end
        if (ctrl_cmd.load_result)
        begin
            rsp_value_reg  <= rd_ok_reg ? rd_data_reg : '0;
            rsp_status_reg <= res_status_reg;
            rsp_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.access)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                rd_ok_reg <= rd_ok_next;
            end
            if (ctrl_cmd.load_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.rsp_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = rsp_value_reg;
    assign status     = rsp_status_reg;
    assign is_empty   = (rsp_count_reg == '0);
    assign occupancy  = rsp_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("deq_datapath: entry count above depth");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_result |-> (!rsp_valid_reg || rsp_ready))
        else $error("deq_datapath: response overwritten before transaction");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.access && mem_we) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("deq_datapath: push did not grow the queue");

    a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_cmd.access |=> $stable(count_reg) && $stable(head_reg))
        else $error("deq_datapath: ring pointers moved outside an access");

    a_full_on_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.access && res_status_next == deq_pkg::ST_FULL)
            |-> (cmd_reg == deq_pkg::CMD_PUSH_FRONT || cmd_reg == deq_pkg::CMD_PUSH_BACK))
        else $error("deq_datapath: full status on a non-push command");

endmodule

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words held in a ring buffer.
// Steps: accept the command, ring access with registered memory read, and
// response load, which waits until the response register is free. A command
// is accepted only once the previous one is through; the response register
// can still hold the previous result while the next command is accepted.
// Reset: head index and count clear at once; storage is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    deq_pkg::ctrl_cmd_t  ctrl_cmd;
    deq_pkg::dp_status_t dp_status;
    logic                req_ready;
    logic                rsp_valid;
    logic                is_empty;
    logic [CNT_W-1:0]    occupancy;
    logic signed [deq_pkg::DATA_W-1:0] read_value;
    logic [deq_pkg::STATUS_W-1:0]      status;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_cmd   (ctrl_cmd),
        .dp_status  (dp_status),
        .cmd        (req.cmd),
        .push_value (req.push_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp.ready),
        .read_value (read_value),
        .status     (status),
        .is_empty   (is_empty),
        .occupancy  (occupancy)
    );

    assign req.ready      = req_ready;
    assign rsp.valid      = rsp_valid;
    assign rsp.read_value = read_value;
    assign rsp.status     = status;
    assign rsp.is_empty   = is_empty;
    assign rsp.occupancy  = occupancy;

endmodule
